>>> rtl/core/g2e_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// geodetic to ECEF converter. No dependencies.
package g2e_pkg;

  typedef logic [63:0] word_t;

  // Fixed-point constants (Q60 unless noted)
  localparam int CORDIC_STEPS = 60;
  localparam int NEWTON_STEPS = 8;
  localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q60   = 64'd1 << 60;
  localparam logic [63:0] THREE_Q60 = 64'd3 << 60;
  localparam logic [63:0] GAIN_SEED = THREE_Q60 / 64'd5;
  localparam logic [63:0] DEG_RAD_K = (PI_Q62 + 64'd22) / 64'd45;
  localparam logic [63:0] OUT_MAX   = 64'd8589934591;

  // Widths of the channel payloads
  localparam int IN_W   = 96;
  localparam int OUT_W  = 104;
  localparam int LON_W  = 33;
  localparam int LAT_W  = 32;
  localparam int HGT_W  = 31;
  localparam int XYZ_W  = 34;
  localparam int AXIS_W = 33;
  localparam int ECC_W  = 38;
  localparam int CFG_W  = 38;

  // Register indexes on the configuration port
  localparam logic REG_SEMI_MAJOR = 1'b0;
  localparam logic REG_ECC_SQ     = 1'b1;

  // Pipeline timing
  localparam int MUL_LAT    = 5;
  localparam int TRIG_LAT   = 1 + MUL_LAT + CORDIC_STEPS + 1;
  localparam int NEWTON_LAT = 3 * MUL_LAT + 1;
  localparam int S_N30      = TRIG_LAT + 2 * MUL_LAT + 1 + NEWTON_STEPS * NEWTON_LAT + MUL_LAT;
  localparam int S_NH       = S_N30 + MUL_LAT + 1;
  localparam int TOTAL_LAT  = S_NH + 2 * MUL_LAT + 1;
  localparam int H_DLY      = S_N30 + MUL_LAT;
  localparam int CB_DLY     = S_NH - TRIG_LAT;
  localparam int CL_DLY     = S_NH + MUL_LAT - TRIG_LAT;

  // One CORDIC cell's payload
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic               flip;
  } cord_t;

  // One Newton step's payload
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] y;
  } nwt_t;

  // Rounded (a*b) >> s, constants only
  function automatic logic [63:0] mulsh_c(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return p[s +: 64];
  endfunction

  // arctan(2^-i) in Q60 from the odd power series, pi/4 directly for i = 0
  function automatic logic [63:0] atan_val(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    sum = '0;
    if (i == 0) return (PI_Q62 + 64'd8) >> 4;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        sum  = k[0] ? sum - term : sum + term;
      end
    end
    return (sum + 64'd2) >> 2;
  endfunction

  // CORDIC start value: 1/sqrt(prod(1+2^-2i)) by Newton iteration
  function automatic logic [63:0] gain_val();
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] w;
    g = ONE_Q60;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (2 * i < 62) g = g + (g >> (2 * i));
    end
    y = GAIN_SEED;
    for (int n = 0; n < NEWTON_STEPS; n++) begin
      t = mulsh_c(y, y, 60);
      u = mulsh_c(g, t, 60);
      w = (u > THREE_Q60) ? 64'd0 : THREE_Q60 - u;
      y = mulsh_c(y, w, 61);
    end
    return y;
  endfunction

  localparam logic [63:0] CORDIC_GAIN = gain_val();

endpackage

>>> rtl/core/g2e_mul.sv
// 64x64 multiplier with rounded right shift, signed or magnitude mode.
// Five stages built from 32x32 partial products. Uses g2e_pkg.
module g2e_mul (
  input  logic            clk,
  input  logic            en,
  input  logic            sgn,
  input  logic [5:0]      shamt,
  input  g2e_pkg::word_t  a,
  input  g2e_pkg::word_t  b,
  output g2e_pkg::word_t  p
);
  import g2e_pkg::*;

  logic [63:0]  am_r, bm_r;
  logic [3:0]   neg_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum_r;
  logic [63:0]  rnd_r;
  logic [63:0]  p_r;
  logic [127:0] sum_nxt, rsum;

  always_comb begin
    sum_nxt = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
            + {p11_r, 64'd0};
    rsum    = (sum_r + (128'd1 << (shamt - 6'd1))) >> shamt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and result sign
      am_r     <= (sgn && a[63]) ? -a : a;
      bm_r     <= (sgn && b[63]) ? -b : b;
      neg_r[0] <= sgn && (a[63] ^ b[63]);
      neg_r[3:1] <= neg_r[2:0];
      // partial products
      p00_r <= am_r[31:0]  * bm_r[31:0];
      p01_r <= am_r[31:0]  * bm_r[63:32];
      p10_r <= am_r[63:32] * bm_r[31:0];
      p11_r <= am_r[63:32] * bm_r[63:32];
      // sum, round, sign
      sum_r <= sum_nxt;
      rnd_r <= rsum[63:0];
      p_r   <= neg_r[3] ? -rnd_r : rnd_r;
    end
  end

  assign p = p_r;

endmodule

>>> rtl/core/g2e_cordic_cell.sv
// One CORDIC rotation cell: fixed shift, fixed arctangent, one register.
// Uses g2e_pkg.
module g2e_cordic_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [5:0]            shamt,
  input  g2e_pkg::word_t        atan_v,
  input  g2e_pkg::cord_t        d_i,
  output g2e_pkg::cord_t        d_o
);
  import g2e_pkg::*;

  cord_t d_r, d_nxt;
  logic signed [63:0] dx, dy;

  // rotate toward zero residual angle
  always_comb begin
    dx    = d_i.y >>> shamt;
    dy    = d_i.x >>> shamt;
    d_nxt = d_i;
    if (!d_i.z[63]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - signed'(atan_v);
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + signed'(atan_v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

>>> rtl/core/g2e_newton.sv
// One Newton step of the reciprocal square root y' = y(3 - v*y*y)/2, Q60.
// Sixteen stages, three multipliers. Uses g2e_pkg, g2e_mul.
module g2e_newton (
  input  logic          clk,
  input  logic          en,
  input  g2e_pkg::nwt_t d_i,
  output g2e_pkg::nwt_t d_o
);
  import g2e_pkg::*;

  logic [63:0] vd_r [NEWTON_LAT];
  logic [63:0] yd_r [NEWTON_LAT - MUL_LAT];
  logic [63:0] t, u, w_r, yn;

  // y*y
  g2e_mul u_sq (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd60),
                .a(d_i.y), .b(d_i.y), .p(t));
  // v*y*y
  g2e_mul u_vt (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd60),
                .a(vd_r[MUL_LAT-1]), .b(t), .p(u));
  // y*(3 - u)/2
  g2e_mul u_yw (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd61),
                .a(yd_r[NEWTON_LAT-MUL_LAT-1]), .b(w_r), .p(yn));

  always_ff @(posedge clk) begin
    if (en) begin
      vd_r[0] <= d_i.v;
      for (int i = 1; i < NEWTON_LAT; i++) vd_r[i] <= vd_r[i-1];
      yd_r[0] <= d_i.y;
      for (int i = 1; i < NEWTON_LAT - MUL_LAT; i++) yd_r[i] <= yd_r[i-1];
      w_r <= (u > THREE_Q60) ? 64'd0 : THREE_Q60 - u;
    end
  end

  assign d_o.v = vd_r[NEWTON_LAT-1];
  assign d_o.y = yn;

endmodule

>>> rtl/core/g2e_trig.sv
// Angle in degrees (Q24) to cosine and sine (Q60): range reduction,
// radian scaling and a row of CORDIC cells. Uses g2e_pkg, g2e_mul, g2e_cordic_cell.
module g2e_trig (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [32:0]     angle,
  output g2e_pkg::word_t         cos_o,
  output g2e_pkg::word_t         sin_o
);
  import g2e_pkg::*;

  localparam logic signed [33:0] D90  = 34'sd1509949440;
  localparam logic signed [33:0] D180 = 34'sd3019898880;
  localparam logic signed [33:0] D360 = 34'sd6039797760;

  logic signed [33:0] d, m1, m2;
  logic               flip_nxt;
  logic signed [33:0] m_r;
  logic               flip_r;
  logic [MUL_LAT-1:0] flipd_r;
  logic [63:0]        z;
  cord_t              chain [CORDIC_STEPS+1];
  logic [63:0]        cs_r, sn_r;

  // wrap into (-180,180], then fold into [-90,90]
  always_comb begin
    d = {angle[32], angle};
    if (d > D180)       m1 = d - D360;
    else if (d <= -D180) m1 = d + D360;
    else                m1 = d;
    flip_nxt = 1'b0;
    m2       = m1;
    if (m1 > D90) begin
      m2       = m1 - D180;
      flip_nxt = 1'b1;
    end else if (m1 < -D90) begin
      m2       = m1 + D180;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= m2;
      flip_r  <= flip_nxt;
      flipd_r <= {flipd_r[MUL_LAT-2:0], flip_r};
    end
  end

  // degrees to radians, Q60
  g2e_mul u_rad (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd28),
                 .a({{30{m_r[33]}}, m_r}), .b(DEG_RAD_K), .p(z));

  assign chain[0].x    = signed'(CORDIC_GAIN);
  assign chain[0].y    = '0;
  assign chain[0].z    = signed'(z);
  assign chain[0].flip = flipd_r[MUL_LAT-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    g2e_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shamt (6'(i)),
      .atan_v(atan_val(i)),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
      sn_r <= chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
    end
  end

  assign cos_o = cs_r;
  assign sin_o = sn_r;

endmodule

>>> rtl/core/geodetic_to_ecef_unit.sv
// Top level of the geodetic to ECEF converter: config registers, trig units,
// Newton chain, final products and output rounding. Uses g2e_pkg and all g2e_ modules.
//
//   port group | dir | beat contents
//   in_*       | in  | tdata: longitude[32:0], latitude[64:33], height[95:65]
//   out_*      | out | tdata: ecef_x[33:0], ecef_y[67:34], ecef_z[101:68], 0 pad
//   cfg_*      | in  | index 0 semi_major_axis, index 1 ecc_squared
//
// One position per cycle unless a result waits; the depth is set by the 60-cell CORDIC row,
// eight Newton steps and the 5-stage multipliers.
// The whole pipeline advances together; it holds while a result waits.
// Reset clears the valid line and loads WGS84 defaults; config is always ready.
module geodetic_to_ecef_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [g2e_pkg::IN_W-1:0]    in_tdata,   // longitude, latitude, height
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [g2e_pkg::OUT_W-1:0]   out_tdata,  // ecef_x, ecef_y, ecef_z, pad
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [g2e_pkg::CFG_W-1:0]   cfg_data
);
  import g2e_pkg::*;

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_r;
  logic [AXIS_W-1:0]    axis_r;
  logic [ECC_W-1:0]     ecc_r;
  logic [63:0]          e2;

  logic [63:0] cl, sl, cb, sb;
  logic [63:0] s2, q, v_r, n30, m2;
  nwt_t        nw [NEWTON_STEPS+1];
  logic [HGT_W-1:0] hd_r [H_DLY];
  logic [63:0] cbd_r [CB_DLY];
  logic [63:0] sbd_r [CB_DLY];
  logic [63:0] cld_r [CL_DLY];
  logic [63:0] sld_r [CL_DLY];
  logic [63:0] n30d_r [MUL_LAT];
  logic [63:0] zpd_r [MUL_LAT];
  logic signed [63:0] h30;
  logic [63:0] nh_r, nz_r, t, zp, xp, yp;
  logic [XYZ_W-1:0] ox, oy, oz;

  // round Q30 to Q10 on the magnitude, saturate
  function automatic logic [XYZ_W-1:0] to_out(input logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    logic [63:0] r;
    mag = v[63] ? -v : v;
    m   = (mag + (64'd1 << 19)) >> 20;
    if (m > OUT_MAX) m = OUT_MAX;
    r   = v[63] ? -m : m;
    return r[XYZ_W-1:0];
  endfunction

  assign en         = out_tready || !out_tvalid;
  assign in_tready  = en;
  assign out_tvalid = vld_r[TOTAL_LAT-1];
  assign cfg_ready  = 1'b1;
  assign e2         = {6'd0, ecc_r, 20'd0};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= 33'd6531212288;
      ecc_r  <= 38'd7360548636;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEMI_MAJOR: axis_r <= cfg_data[AXIS_W-1:0];
        REG_ECC_SQ:     ecc_r  <= cfg_data[ECC_W-1:0];
        default: ;
      endcase
    end
  end

  // beat valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-2:0], in_tvalid};
    end
  end

  // sine and cosine of both angles
  g2e_trig u_lon (.clk(clk), .en(en), .angle(signed'(in_tdata[32:0])),
                  .cos_o(cl), .sin_o(sl));
  g2e_trig u_lat (.clk(clk), .en(en),
                  .angle(signed'({in_tdata[64], in_tdata[64:33]})),
                  .cos_o(cb), .sin_o(sb));

  // 1 - e2*sin^2(lat)
  g2e_mul u_s2 (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd60), .a(sb), .b(sb), .p(s2));
  g2e_mul u_q  (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd60), .a(e2), .b(s2), .p(q));

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= ONE_Q60 - q;
    end
  end

  // reciprocal square root chain
  assign nw[0].v = v_r;
  assign nw[0].y = ONE_Q60;
  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_nwt
    g2e_newton u_nwt (.clk(clk), .en(en), .d_i(nw[i]), .d_o(nw[i+1]));
  end

  // N and N*e2
  g2e_mul u_n30 (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd40),
                 .a({31'd0, axis_r}), .b(nw[NEWTON_STEPS].y), .p(n30));
  g2e_mul u_m2  (.clk(clk), .en(en), .sgn(1'b0), .shamt(6'd60),
                 .a(n30), .b(e2), .p(m2));

  // delay lines for side operands
  always_ff @(posedge clk) begin
    if (en) begin
      hd_r[0]   <= in_tdata[95:65];
      for (int i = 1; i < H_DLY; i++) hd_r[i] <= hd_r[i-1];
      cbd_r[0]  <= cb;
      sbd_r[0]  <= sb;
      for (int i = 1; i < CB_DLY; i++) begin
        cbd_r[i] <= cbd_r[i-1];
        sbd_r[i] <= sbd_r[i-1];
      end
      cld_r[0]  <= cl;
      sld_r[0]  <= sl;
      for (int i = 1; i < CL_DLY; i++) begin
        cld_r[i] <= cld_r[i-1];
        sld_r[i] <= sld_r[i-1];
      end
      n30d_r[0] <= n30;
      zpd_r[0]  <= zp;
      for (int i = 1; i < MUL_LAT; i++) begin
        n30d_r[i] <= n30d_r[i-1];
        zpd_r[i]  <= zpd_r[i-1];
      end
    end
  end

  // N+h and N(1-e2)+h, Q30
  assign h30 = {{13{hd_r[H_DLY-1][HGT_W-1]}}, hd_r[H_DLY-1], 20'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      nh_r <= n30d_r[MUL_LAT-1] + h30;
      nz_r <= n30d_r[MUL_LAT-1] - m2 + h30;
    end
  end

  // final products
  g2e_mul u_t  (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd60),
                .a(nh_r), .b(cbd_r[CB_DLY-1]), .p(t));
  g2e_mul u_zp (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd60),
                .a(nz_r), .b(sbd_r[CB_DLY-1]), .p(zp));
  g2e_mul u_xp (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd60),
                .a(t), .b(cld_r[CL_DLY-1]), .p(xp));
  g2e_mul u_yp (.clk(clk), .en(en), .sgn(1'b1), .shamt(6'd60),
                .a(t), .b(sld_r[CL_DLY-1]), .p(yp));

  // output register
  assign ox = to_out(xp);
  assign oy = to_out(yp);
  assign oz = to_out(zpd_r[MUL_LAT-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {2'd0, oz, oy, ox};
    end
  end

`ifndef SYNTHESIS
  // a held pipeline keeps its occupancy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("valid line moved while held");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result after reset");

  // saturation is symmetric, the most negative code never appears
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33:0] != 34'h200000000 &&
                    out_tdata[67:34] != 34'h200000000 &&
                    out_tdata[101:68] != 34'h200000000))
    else $error("output beyond saturation range");
`endif

endmodule
